>>> design/spherical_texcoord_map_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off while rst_ni low.
// ----------------------------------------------------------------------------
`ifndef SPHERICAL_TEXCOORD_MAP_ASSERT_SVH
`define SPHERICAL_TEXCOORD_MAP_ASSERT_SVH

// same-cycle implication
`define STCM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stcm: same-cycle check failed");

// next-cycle implication
`define STCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stcm: next-cycle check failed");

`endif

>>> design/stcm_pkg.sv
// ----------------------------------------------------------------------------
// stcm_pkg
// Types, constants and the arctangent table of the spherical texcoord mapper.
// ----------------------------------------------------------------------------
package stcm_pkg;

  localparam int CordicStages = 16;
  localparam int CoordBits    = 16;
  localparam int Prescale     = 40 - CoordBits;
  localparam int CordicW      = 44;
  localparam int GainW        = 22;
  localparam int GainShift    = 20;
  localparam int AtanLen      = 24;
  localparam int QW           = 18;

  localparam logic signed [GainW-1:0] GainQ20 = 22'sd1726753;
  localparam logic [31:0] HalfTurn    = 32'h8000_0000;
  localparam logic [QW-1:0] UHalfQ16  = 18'd32768;

  localparam logic [31:0] AtanTurns [AtanLen] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef logic signed [CordicW-1:0] cw_t;

  typedef enum logic [1:0] {
    ModePlain  = 2'd0,
    ModeFold   = 2'd1,
    ModeTriple = 2'd2
  } mode_e;

  typedef struct packed {
    logic [31:0] phi;
    cw_t         yk;
    logic        zero;
    logic        last;
  } side_t;

endpackage

>>> design/spherical_texcoord_map.sv
// ----------------------------------------------------------------------------
// spherical_texcoord_map
// Vertex position to spherical texture coordinates (u, v) in unsigned Q2.16.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   pos_x/y/z_i, last_vertex_i
//   out      source     out_valid_o / out_stall_i tex_u/v_o, zero_vector_o,
//                                                 last_out_o
//   cfg      sink       map_mode_we_i             map_mode_i
//
// One beat per cycle unless a result beat is stalled; input stage, two CORDIC
// chains of 17 stages each (prerotation plus one micro-rotation per stage), two
// post-processing stages. The whole pipe advances when the output register
// is empty or taken; in_stall_o is high only while a result beat is stalled.
// Reset clears valid bits and map_mode.
// ----------------------------------------------------------------------------
module spherical_texcoord_map import stcm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [15:0]   pos_x_i,
  input  logic [15:0]   pos_y_i,
  input  logic [15:0]   pos_z_i,
  input  logic          last_vertex_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [QW-1:0] tex_u_o,
  output logic [QW-1:0] tex_v_o,
  output logic          zero_vector_o,
  output logic          last_out_o,
  input  logic          map_mode_we_i,
  input  logic [1:0]    map_mode_i
);

  logic                              en;
  logic [1:0]                        map_mode_q;
  logic signed [CoordBits-1:0]       x_c, y_c, z_c;
  logic signed [CoordBits+GainW-1:0] prod;
  cw_t                               yk;
  logic                              f_vld_q;
  cw_t                               f_px_q, f_py_q;
  side_t                             f_side_q, f_side_d;
  logic                              c1_vld;
  logic [31:0]                       c1_ang;
  cw_t                               c1_mag;
  side_t                             c1_side, c2_side_in;
  logic                              c2_vld;
  logic [31:0]                       c2_ang;
  side_t                             c2_side;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_mode_q <= ModePlain;
    end else if (map_mode_we_i) begin
      map_mode_q <= map_mode_i;
    end
  end

  assign x_c  = signed'(pos_x_i[CoordBits-1:0]);
  assign y_c  = signed'(pos_y_i[CoordBits-1:0]);
  assign z_c  = signed'(pos_z_i[CoordBits-1:0]);
  assign prod = (CoordBits+GainW)'(y_c) * (CoordBits+GainW)'(GainQ20);

  if (Prescale >= GainShift) begin : g_yk_up
    assign yk = CordicW'(prod) <<< (Prescale - GainShift);
  end else begin : g_yk_dn
    assign yk = CordicW'(prod >>> (GainShift - Prescale));
  end

  always_comb begin
    f_side_d.phi  = '0;
    f_side_d.yk   = yk;
    f_side_d.zero = (x_c == '0) && (y_c == '0) && (z_c == '0);
    f_side_d.last = last_vertex_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_px_q   <= CordicW'(z_c) <<< Prescale;
      f_py_q   <= CordicW'(x_c) <<< Prescale;
      f_side_q <= f_side_d;
    end
  end

  stcm_cordic u_cordic_phi (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (f_vld_q),
    .px_i   (f_px_q),
    .py_i   (f_py_q),
    .side_i (f_side_q),
    .vld_o  (c1_vld),
    .ang_o  (c1_ang),
    .mag_o  (c1_mag),
    .side_o (c1_side)
  );

  always_comb begin
    c2_side_in     = c1_side;
    c2_side_in.phi = c1_ang;
  end

  stcm_cordic u_cordic_theta (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (c1_vld),
    .px_i   (c1_side.yk),
    .py_i   (c1_mag),
    .side_i (c2_side_in),
    .vld_o  (c2_vld),
    .ang_o  (c2_ang),
    .mag_o  (),
    .side_o (c2_side)
  );

  stcm_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (c2_vld),
    .phi_i   (c2_side.phi),
    .theta_i (c2_ang),
    .zero_i  (c2_side.zero),
    .last_i  (c2_side.last),
    .mode_i  (map_mode_q),
    .vld_o   (out_valid_o),
    .tex_u_o (tex_u_o),
    .tex_v_o (tex_v_o),
    .zero_o  (zero_vector_o),
    .last_o  (last_out_o)
  );

endmodule

>>> design/stcm_cordic.sv
// ----------------------------------------------------------------------------
// stcm_cordic
// Pipelined CORDIC vectoring: half-turn prerotation, then one micro-rotation
// per register stage. Angle in binary turns, magnitude scaled by the gain.
// ----------------------------------------------------------------------------
module stcm_cordic import stcm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  cw_t         px_i,
  input  cw_t         py_i,
  input  side_t       side_i,
  output logic        vld_o,
  output logic [31:0] ang_o,
  output cw_t         mag_o,
  output side_t       side_o
);

  logic        vld_q  [CordicStages+1];
  cw_t         px_q   [CordicStages+1];
  cw_t         py_q   [CordicStages+1];
  logic [31:0] ang_q  [CordicStages+1];
  logic        zero_q [CordicStages+1];
  side_t       side_q [CordicStages+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (px_i[CordicW-1]) begin
        px_q[0]  <= -px_i;
        py_q[0]  <= -py_i;
        ang_q[0] <= HalfTurn;
      end else begin
        px_q[0]  <= px_i;
        py_q[0]  <= py_i;
        ang_q[0] <= '0;
      end
      zero_q[0] <= (px_i == '0) && (py_i == '0);
      side_q[0] <= side_i;
    end
  end

  for (genvar g = 0; g < CordicStages; g++) begin : g_stage
    cw_t xs;
    cw_t ys;

    assign xs = px_q[g] >>> g;
    assign ys = py_q[g] >>> g;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (py_q[g][CordicW-1]) begin
          px_q[g+1]  <= px_q[g] - ys;
          py_q[g+1]  <= py_q[g] + xs;
          ang_q[g+1] <= ang_q[g] - AtanTurns[g];
        end else begin
          px_q[g+1]  <= px_q[g] + ys;
          py_q[g+1]  <= py_q[g] - xs;
          ang_q[g+1] <= ang_q[g] + AtanTurns[g];
        end
        zero_q[g+1] <= zero_q[g];
        side_q[g+1] <= side_q[g];
      end
    end
  end

  assign vld_o  = vld_q[CordicStages];
  assign ang_o  = zero_q[CordicStages] ? '0 : ang_q[CordicStages];
  assign mag_o  = px_q[CordicStages];
  assign side_o = side_q[CordicStages];

endmodule

>>> design/stcm_post.sv
// ----------------------------------------------------------------------------
// stcm_post
// Angles to texture coordinates: fold and clamp, then mode scaling and
// Q2.16 rounding into the output register.
// ----------------------------------------------------------------------------
module stcm_post import stcm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [31:0]   phi_i,
  input  logic [31:0]   theta_i,
  input  logic          zero_i,
  input  logic          last_i,
  input  logic [1:0]    mode_i,
  output logic          vld_o,
  output logic [QW-1:0] tex_u_o,
  output logic [QW-1:0] tex_v_o,
  output logic          zero_o,
  output logic          last_o
);

  logic               vld_a_q;
  logic [31:0]        u_a_q, u_a_d;
  logic [32:0]        v_a_q, v_a_d;
  logic               zero_a_q;
  logic               last_a_q;
  logic [31:0]        u_raw;
  logic signed [31:0] ts;
  logic [31:0]        t;
  logic [34:0]        u_m, v_m;
  logic [35:0]        u_r, v_r;
  logic               vld_q;
  logic [QW-1:0]      tex_u_q, tex_u_d;
  logic [QW-1:0]      tex_v_q, tex_v_d;
  logic               zero_q;
  logic               last_q;

  always_comb begin
    u_raw = phi_i + HalfTurn;
    u_a_d = (u_raw > HalfTurn) ? (32'd0 - u_raw) : u_raw;
    ts    = signed'(theta_i);
    if (ts < -32'sh4000_0000) begin
      t = HalfTurn;
    end else if (ts < 0) begin
      t = '0;
    end else begin
      t = theta_i;
    end
    v_a_d = {t, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_q   <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_q   <= vld_a_q;
    end
  end

  always_comb begin
    unique case (mode_i)
      ModeFold: begin
        u_m = 35'(u_a_q >> 1);
        v_m = (v_a_q > 33'(HalfTurn)) ? 35'(33'h1_0000_0000 - v_a_q) : 35'(v_a_q);
      end
      ModeTriple: begin
        u_m = 35'(u_a_q) + {2'b0, u_a_q, 1'b0};
        v_m = 35'(v_a_q) + {1'b0, v_a_q, 1'b0};
      end
      default: begin
        u_m = 35'(u_a_q);
        v_m = 35'(v_a_q);
      end
    endcase
    u_r = 36'(u_m) + 36'h8000;
    v_r = 36'(v_m) + 36'h8000;
    if (zero_a_q) begin
      tex_u_d = UHalfQ16;
      tex_v_d = '0;
    end else begin
      tex_u_d = u_r[33:16];
      tex_v_d = v_r[33:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_a_q    <= u_a_d;
      v_a_q    <= v_a_d;
      zero_a_q <= zero_i;
      last_a_q <= last_i;
      tex_u_q  <= tex_u_d;
      tex_v_q  <= tex_v_d;
      zero_q   <= zero_a_q;
      last_q   <= last_a_q;
    end
  end

  assign vld_o   = vld_q;
  assign tex_u_o = tex_u_q;
  assign tex_v_o = tex_v_q;
  assign zero_o  = zero_q;
  assign last_o  = last_q;

endmodule

>>> design/stcm_checker.sv
// ----------------------------------------------------------------------------
// stcm_checker
// Port-level checks on the spherical texcoord mapper, bound to the top level.
// ----------------------------------------------------------------------------
`include "spherical_texcoord_map_assert.svh"

module stcm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [15:0] pos_x_i,
  input logic [15:0] pos_y_i,
  input logic [15:0] pos_z_i,
  input logic        last_vertex_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [17:0] tex_u_o,
  input logic [17:0] tex_v_o,
  input logic        zero_vector_o,
  input logic        last_out_o,
  input logic        map_mode_we_i,
  input logic [1:0]  map_mode_i
);

  `STCM_ASSERT_IMPL(a_stall_only_when_blocked, 1'b1, in_stall_o == (out_valid_o && out_stall_i))
  `STCM_ASSERT_IMPL(a_zero_default, out_valid_o && zero_vector_o, tex_u_o == 18'd32768 && tex_v_o == 18'd0)
  `STCM_ASSERT_IMPL(a_coord_range, out_valid_o, tex_u_o <= 18'd98304 && tex_v_o <= 18'd196608)
  `STCM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(tex_u_o) && $stable(tex_v_o))

endmodule

bind spherical_texcoord_map stcm_checker u_stcm_checker (.*);

>>> tb/stcm_texcoord_checker.sv
// ----------------------------------------------------------------------------
// stcm_texcoord_checker
// Watches the vertex and texcoord channels of spherical_texcoord_map. It
// computes the expected (u, v) beat for every accepted vertex with a
// bit-exact CORDIC model, queues it, and compares each result beat field by
// field. The failure count and the number of pending beats go to the top.
// ----------------------------------------------------------------------------
module stcm_texcoord_checker import stcm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  logic [15:0]   pos_x_i,
  input  logic [15:0]   pos_y_i,
  input  logic [15:0]   pos_z_i,
  input  logic          last_vertex_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  logic [QW-1:0] tex_u_i,
  input  logic [QW-1:0] tex_v_i,
  input  logic          zero_vector_i,
  input  logic          last_out_i,
  input  logic          map_mode_we_i,
  input  logic [1:0]    map_mode_i,
  output int            mismatches_o,
  output int            outstanding_o
);

  typedef struct packed {
    logic [QW-1:0] u;
    logic [QW-1:0] v;
    logic          zero;
    logic          last;
  } tex_beat_t;

  tex_beat_t  expected_tex[$];
  logic [1:0] active_mode = ModePlain;
  int         mismatches  = 0;
  int         pending_cnt = 0;

  assign mismatches_o  = mismatches;
  assign outstanding_o = pending_cnt;

  function automatic logic [31:0] vector_turns(input longint px_in, input longint py_in,
                                               output longint mag);
    longint      px;
    longint      py;
    longint      xs;
    longint      ys;
    logic [31:0] ang;
    px  = px_in;
    py  = py_in;
    ang = '0;
    mag = 0;
    if (px == 0 && py == 0) return ang;
    if (px < 0) begin
      px  = -px;
      py  = -py;
      ang = HalfTurn;
    end
    for (int i = 0; i < CordicStages && i < AtanLen; i++) begin
      xs = px >>> i;
      ys = py >>> i;
      if (py < 0) begin
        px  = px - ys;
        py  = py + xs;
        ang = ang - AtanTurns[i];
      end else begin
        px  = px + ys;
        py  = py - xs;
        ang = ang + AtanTurns[i];
      end
    end
    mag = px;
    return ang;
  endfunction

  function automatic logic [QW-1:0] round_q16(input logic [63:0] frac32);
    logic [63:0] q;
    q = (frac32 + 64'h8000) >> 16;
    return q[QW-1:0];
  endfunction

  function automatic tex_beat_t map_vertex(input logic signed [15:0] x,
                                           input logic signed [15:0] y,
                                           input logic signed [15:0] z,
                                           input logic lst, input logic [1:0] mode);
    tex_beat_t   beat;
    longint      scale;
    longint      xs;
    longint      ys;
    longint      zs;
    longint      yk;
    longint      radius;
    longint      spare_mag;
    logic [31:0] phi;
    logic [31:0] theta;
    logic [63:0] u;
    logic [63:0] v;
    logic [63:0] t;
    int          ts;
    beat.last = lst;
    if (x == 0 && y == 0 && z == 0) begin
      beat.u    = UHalfQ16;
      beat.v    = '0;
      beat.zero = 1'b1;
      return beat;
    end
    scale  = longint'(1) <<< Prescale;
    xs     = longint'(x) * scale;
    ys     = longint'(y) * scale;
    zs     = longint'(z) * scale;
    phi    = vector_turns(zs, xs, radius);
    yk     = (ys * longint'(GainQ20)) >>> GainShift;
    theta  = vector_turns(yk, radius, spare_mag);

    u = {32'b0, phi + HalfTurn};
    if (u > {32'b0, HalfTurn}) u = 64'h1_0000_0000 - u;

    ts = $signed(theta);
    if (ts < -32'sd1073741824) t = {32'b0, HalfTurn};
    else if (ts < 0)           t = '0;
    else                       t = {32'b0, theta};
    v = t << 1;

    if (mode == ModeFold) begin
      if (v > {32'b0, HalfTurn}) v = 64'h1_0000_0000 - v;
      u = u >> 1;
    end else if (mode == ModeTriple) begin
      u = u * 3;
      v = v * 3;
    end

    beat.u    = round_q16(u);
    beat.v    = round_q16(v);
    beat.zero = 1'b0;
    return beat;
  endfunction

  function automatic void check_field(input string field, input logic [QW-1:0] want,
                                      input logic [QW-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    tex_beat_t want;
    if (!rst_ni) begin
      active_mode = ModePlain;
      expected_tex.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_tex.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing pending, expected none, actual u %0d v %0d",
                   $time, tex_u_i, tex_v_i);
        end else begin
          want = expected_tex.pop_front();
          check_field("tex_u", want.u, tex_u_i);
          check_field("tex_v", want.v, tex_v_i);
          check_field("zero_vector", QW'(want.zero), QW'(zero_vector_i));
          check_field("last_out", QW'(want.last), QW'(last_out_i));
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_tex.push_back(map_vertex(pos_x_i, pos_y_i, pos_z_i, last_vertex_i,
                                          active_mode));
      if (map_mode_we_i) active_mode = map_mode_i;
    end
    pending_cnt <= expected_tex.size();
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for spherical_texcoord_map. Sends corner vertices in
// three map modes and random vertex streams in every map mode, with random
// sender gaps and result stalls in three mixes; the checker predicts and compares beats.
// ----------------------------------------------------------------------------
module tb_top;
  import stcm_pkg::*;

  localparam logic [1:0]  ModeSpare   = 2'd3;
  localparam logic [15:0] CoordMax    = 16'h7FFF;
  localparam logic [15:0] CoordMin    = 16'h8000;
  localparam int          DrainCycles = 40;

  logic          clk           = 1'b0;
  logic          rst_n         = 1'b0;
  logic          in_valid      = 1'b0;
  logic          in_stall;
  logic [15:0]   pos_x         = '0;
  logic [15:0]   pos_y         = '0;
  logic [15:0]   pos_z         = '0;
  logic          last_vertex   = 1'b0;
  logic          out_valid;
  logic          out_stall     = 1'b0;
  logic [QW-1:0] tex_u;
  logic [QW-1:0] tex_v;
  logic          zero_vector;
  logic          last_out;
  logic          map_mode_we   = 1'b0;
  logic [1:0]    map_mode      = ModePlain;
  int            idle_pct      = 0;
  int            stall_pct     = 0;
  int            vertices_sent = 0;
  int            mismatches;
  int            outstanding;

  spherical_texcoord_map dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .pos_x_i       (pos_x),
    .pos_y_i       (pos_y),
    .pos_z_i       (pos_z),
    .last_vertex_i (last_vertex),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .tex_u_o       (tex_u),
    .tex_v_o       (tex_v),
    .zero_vector_o (zero_vector),
    .last_out_o    (last_out),
    .map_mode_we_i (map_mode_we),
    .map_mode_i    (map_mode)
  );

  stcm_texcoord_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .pos_x_i       (pos_x),
    .pos_y_i       (pos_y),
    .pos_z_i       (pos_z),
    .last_vertex_i (last_vertex),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .tex_u_i       (tex_u),
    .tex_v_i       (tex_v),
    .zero_vector_i (zero_vector),
    .last_out_i    (last_out),
    .map_mode_we_i (map_mode_we),
    .map_mode_i    (map_mode),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_vertex(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input logic lst);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    pos_x       <= x;
    pos_y       <= y;
    pos_z       <= z;
    last_vertex <= lst;
    do @(posedge clk); while (in_stall);
    vertices_sent++;
  endtask

  // hold off until every pending beat has come out and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] mode);
    drain();
    map_mode_we <= 1'b1;
    map_mode    <= mode;
    @(posedge clk);
    map_mode_we <= 1'b0;
  endtask

  task automatic send_corners();
    send_vertex('0, '0, '0, 1'b0);
    send_vertex('0, '0, '0, 1'b1);
    send_vertex('0, 16'd100, '0, 1'b0);
    send_vertex('0, -16'sd100, '0, 1'b0);
    send_vertex('0, CoordMax, '0, 1'b0);
    send_vertex('0, CoordMin, '0, 1'b1);
    send_vertex(CoordMax, '0, '0, 1'b0);
    send_vertex(CoordMin, '0, '0, 1'b0);
    send_vertex('0, '0, CoordMax, 1'b0);
    send_vertex('0, '0, CoordMin, 1'b0);
    send_vertex(CoordMax, CoordMax, CoordMax, 1'b0);
    send_vertex(CoordMin, CoordMin, CoordMin, 1'b1);
    send_vertex(CoordMin, CoordMax, CoordMin, 1'b0);
    send_vertex(CoordMax, CoordMin, CoordMax, 1'b0);
    send_vertex(16'd1, CoordMax, '0, 1'b0);
    send_vertex(16'hFFFF, CoordMin, '0, 1'b0);
    send_vertex('0, CoordMin, 16'd1, 1'b0);
    send_vertex(16'd1, '0, 16'hFFFF, 1'b0);
    send_vertex(16'hFFFF, 16'd1, 16'hFFFF, 1'b0);
    send_vertex(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_vertex(16'h5555, 16'hAAAA, 16'h5555, 1'b0);
    send_vertex(16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);
  endtask

  function automatic logic [15:0] small_coord();
    return 16'($urandom_range(8) - 4);
  endfunction

  function automatic logic [15:0] extreme_coord();
    logic [15:0] picks [6] = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
    return picks[$urandom_range(5)];
  endfunction

  task automatic send_random(input int count);
    int          roll;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 2) begin
        x = '0; y = '0; z = '0;
      end else if (roll < 12) begin
        x = '0; y = 16'($urandom); z = '0;
      end else if (roll < 30) begin
        x = small_coord(); y = small_coord(); z = small_coord();
      end else if (roll < 42) begin
        x = extreme_coord(); y = extreme_coord(); z = extreme_coord();
      end else begin
        x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
      end
      send_vertex(x, y, z, 1'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct  = 26;
    stall_pct = 80;
    send_corners();
    set_mode(ModeFold);
    send_random(90);
    set_mode(ModeTriple);
    send_corners();
    send_random(60);

    idle_pct  = 80;
    stall_pct = 26;
    set_mode(ModeSpare);
    send_random(70);
    set_mode(ModeFold);
    send_corners();
    send_random(60);

    idle_pct  = 0;
    stall_pct = 0;
    set_mode(ModePlain);
    send_random(90);
    set_mode(ModeTriple);
    send_random(60);
    drain();

    $display("Summary: %0d vertices (corners and random streams) in all four map modes,",
             vertices_sent);
    $display("Summary: under sender gaps and result stalls in three mixes.");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/stcm_pkg.sv
design/stcm_cordic.sv
design/stcm_post.sv
design/spherical_texcoord_map.sv
design/stcm_checker.sv
tb/stcm_texcoord_checker.sv
tb/tb_top.sv
